[hw/rtl/rard_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rard_pkg: shared types and constants of the RMS-reference apnea detector
// Widths, condition codes, register map and reset values.
// ----------------------------------------------------------------------------
package rard_pkg;

  localparam int WIN_DEPTH  = 64;
  localparam int WIN_AW     = $clog2(WIN_DEPTH);

  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 44;
  localparam int CNT_W      = 13;
  localparam int FRAC_W     = 11;
  localparam int LEVEL_W    = 24;
  localparam int COND_W     = 2;
  localparam int MEAN_SHIFT = 16;
  localparam int DIV_W      = SUM_W + MEAN_SHIFT;
  localparam int SQRT_ITERS = DIV_W / 2;
  localparam int SU_W       = DIV_W + 1;
  localparam int MUL_AW     = LEVEL_W;
  localparam int MUL_BW     = SAMPLE_W;
  localparam int PROD_W     = MUL_AW + MUL_BW;
  localparam int FRAC_SHIFT = 10;

  localparam int CFG_DW     = 32;
  localparam int CFG_AW     = 3;

  typedef logic [COND_W-1:0] cond_t;

  localparam cond_t COND_NORMAL = 2'd0;
  localparam cond_t COND_APNEA  = 2'd1;
  localparam cond_t COND_ERROR  = 2'd2;
  localparam cond_t COND_REREF  = 2'd3;

  localparam logic REG_REF_SAMPLES = 1'b0;
  localparam logic REG_ERR_FRAC    = 1'b1;

  localparam logic [CNT_W-1:0]  REF_SAMPLES_RST = 13'd1024;
  localparam logic [FRAC_W-1:0] ERR_FRAC_RST    = 11'd973;
  localparam logic [FRAC_W-1:0] FRAC_ONE        = 11'd1024;

endpackage

[hw/rtl/rard_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rard_in_if / rard_out_if: sample and result channels
// Valid/ready channels carrying one sample word and one result word.
// ----------------------------------------------------------------------------
interface rard_in_if import rard_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] displacement;
  logic                       restart_reference;

  modport source (output valid, output displacement, output restart_reference,
                  input ready);
  modport sink (input valid, input displacement, input restart_reference,
                output ready);
endinterface

interface rard_out_if import rard_pkg::*; ();
  logic  valid;
  logic  ready;
  cond_t condition;
  logic  reference_ready;

  modport source (output valid, output condition, output reference_ready,
                  input ready);
  modport sink (input valid, input condition, input reference_ready,
                output ready);
endinterface

[hw/rtl/rms_reference_apnea_detector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_reference_apnea_detector: apnea condition from displacement samples
// Sequenced datapath with one shared subtractor and one shared multiplier.
// ----------------------------------------------------------------------------
// in_ch carries one sample word (displacement, restart_reference); out_ch
// returns one result word (condition, reference_ready) per sample, in order.
// cfg_* is an APB write/read port: reference_samples at 0x0, error_fraction
// at 0x4; write only while no sample is in flight.
// in_ch.ready is high only while the sequencer is idle. Per sample:
//   accumulating, no reference yet: square, accumulate, result register;
//   reference in place: the window scan of one entry per cycle through the
//   single read port of the window memory;
//   sample that forms the reference: square, accumulate, 60-step restoring
//   divide and 30-step square root, both on the shared subtractor, then the
//   error-level multiply on the shared multiplier, then the scan.
// The result sits in an output register, so a new sample is taken while it
// waits. If out_ch stalls and a second result is done, the sequencer holds
// until the output register frees.
// Reset (rst_n low, synchronous) restores register defaults, empties the
// window (read back as zero) and drops any pending result.
// ----------------------------------------------------------------------------
module rms_reference_apnea_detector import rard_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  rard_in_if.sink           in_ch,
  rard_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQR  = 4'd1;
  localparam logic [3:0] S_ACC  = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_SQRT = 4'd4;
  localparam logic [3:0] S_ERRM = 4'd5;
  localparam logic [3:0] S_ERRL = 4'd6;
  localparam logic [3:0] S_SCAN = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  localparam logic [WIN_AW:0]  SCAN_END = (WIN_AW+1)'(WIN_DEPTH);
  localparam logic [WIN_AW-1:0] PTR_LAST = WIN_AW'(WIN_DEPTH - 1);
  localparam logic [5:0]       DIV_LAST = 6'(DIV_W - 1);
  localparam logic [5:0]       SQRT_LAST = 6'(SQRT_ITERS - 1);
  localparam logic [DIV_W-1:0] BIT_INIT = DIV_W'(1) << (2 * SQRT_ITERS - 2);

  logic [3:0]                 state_r, state_nxt;
  logic [CNT_W-1:0]           ref_samples_r;
  logic [FRAC_W-1:0]          err_frac_r;
  logic [WIN_AW-1:0]          ptr_r, ptr_nxt;
  logic [WIN_AW:0]            fill_r, fill_nxt;
  logic [SUM_W-1:0]           sum_r, sum_nxt;
  logic [CNT_W-1:0]           taken_r, taken_nxt;
  logic                       refv_r, refv_nxt;
  logic [LEVEL_W-1:0]         ref_lvl_r, ref_lvl_nxt;
  logic [LEVEL_W-1:0]         err_lvl_r, err_lvl_nxt;
  cond_t                      prev_r, prev_nxt;
  logic signed [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic [PROD_W-1:0]          prod_r;
  logic [CNT_W-1:0]           rem_r, rem_nxt;
  logic [DIV_W-1:0]           work_r, work_nxt;
  logic [DIV_W-1:0]           root_r, root_nxt;
  logic [DIV_W-1:0]           bit_r, bit_nxt;
  logic [5:0]                 iter_r, iter_nxt;
  logic [WIN_AW:0]            scan_idx_r, scan_idx_nxt;
  logic                       pend_r, pend_nxt;
  logic                       ref_hit_r, ref_hit_nxt;
  logic                       err_hit_r, err_hit_nxt;
  cond_t                      res_cond_r, res_cond_nxt;
  logic                       res_rdy_r, res_rdy_nxt;
  logic                       out_valid_r, out_valid_nxt;
  cond_t                      out_cond_r, out_cond_nxt;
  logic                       out_rdy_r, out_rdy_nxt;

  logic signed [SAMPLE_W-1:0] win_mem [WIN_DEPTH];
  logic signed [SAMPLE_W-1:0] rdata_r;
  logic                       rd_ok_r;
  logic [WIN_AW-1:0]          rd_addr;
  logic                       accept;
  logic                       cfg_we;

  // shared multiplier and subtractor
  logic [MUL_AW-1:0]          mul_a;
  logic [MUL_BW-1:0]          mul_b;
  logic [SU_W-1:0]            su_a, su_b;
  logic [SU_W:0]              su_res;
  logic                       su_borrow;
  logic [SU_W-1:0]            su_diff;

  logic [SAMPLE_W-1:0]        mag;
  logic [FRAC_W-1:0]          frac_sat;
  logic [CNT_W-1:0]           target;
  logic [SUM_W-1:0]           sum_add;
  logic [CNT_W-1:0]           taken_inc;
  logic [CNT_W:0]             div_trial;
  logic [DIV_W-1:0]           sqrt_trial;
  logic signed [SAMPLE_W-1:0] scan_smp;
  logic signed [LEVEL_W:0]    scaled;
  logic                       ge_ref, ge_err;
  logic                       hit_ref_all, hit_err_all;
  cond_t                      fin_cond;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.condition = out_cond_r;
  assign out_ch.reference_ready = out_rdy_r;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    case (cfg_paddr[2])
      REG_REF_SAMPLES: cfg_prdata = CFG_DW'(ref_samples_r);
      REG_ERR_FRAC:    cfg_prdata = CFG_DW'(err_frac_r);
      default:         cfg_prdata = '0;
    endcase
  end

  assign mag      = sample_r[SAMPLE_W-1] ? SAMPLE_W'(~sample_r + 1'b1) : sample_r;
  assign frac_sat = (err_frac_r > FRAC_ONE) ? FRAC_ONE : err_frac_r;
  assign target   = (ref_samples_r == '0) ? CNT_W'(1) : ref_samples_r;
  assign sum_add  = sum_r + SUM_W'(prod_r[2*SAMPLE_W-1:0]);
  assign taken_inc = taken_r + 1'b1;

  always_comb begin
    if (state_r == S_ERRM) begin
      mul_a = ref_lvl_r;
      mul_b = MUL_BW'(frac_sat);
    end else begin
      mul_a = MUL_AW'(mag);
      mul_b = mag;
    end
  end

  assign div_trial  = {rem_r, work_r[DIV_W-1]};
  assign sqrt_trial = root_r | bit_r;

  always_comb begin
    if (state_r == S_DIV) begin
      su_a = SU_W'(div_trial);
      su_b = SU_W'(taken_r);
    end else begin
      su_a = SU_W'(work_r);
      su_b = SU_W'(sqrt_trial);
    end
  end

  assign su_res    = {1'b0, su_a} - {1'b0, su_b};
  assign su_borrow = su_res[SU_W];
  assign su_diff   = su_res[SU_W-1:0];

  assign rd_addr  = scan_idx_r[WIN_AW-1:0];
  assign scan_smp = rd_ok_r ? rdata_r : '0;
  assign scaled   = {scan_smp[SAMPLE_W-1], scan_smp, 8'b0};
  assign ge_ref   = scaled >= $signed({1'b0, ref_lvl_r});
  assign ge_err   = scaled >= $signed({1'b0, err_lvl_r});
  assign hit_ref_all = ref_hit_r || (pend_r && ge_ref);
  assign hit_err_all = err_hit_r || (pend_r && ge_err);

  always_comb begin
    fin_cond = hit_ref_all ? COND_NORMAL : COND_APNEA;
    if (prev_r == COND_APNEA) begin
      if (!err_hit_r) begin
        fin_cond = COND_ERROR;
      end else if (fin_cond == COND_NORMAL) begin
        fin_cond = COND_REREF;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    taken_nxt     = taken_r;
    refv_nxt      = refv_r;
    ref_lvl_nxt   = ref_lvl_r;
    err_lvl_nxt   = err_lvl_r;
    prev_nxt      = prev_r;
    sample_nxt    = sample_r;
    rem_nxt       = rem_r;
    work_nxt      = work_r;
    root_nxt      = root_r;
    bit_nxt       = bit_r;
    iter_nxt      = iter_r;
    scan_idx_nxt  = scan_idx_r;
    pend_nxt      = 1'b0;
    ref_hit_nxt   = ref_hit_r;
    err_hit_nxt   = err_hit_r;
    res_cond_nxt  = res_cond_r;
    res_rdy_nxt   = res_rdy_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_cond_nxt  = out_cond_r;
    out_rdy_nxt   = out_rdy_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          sample_nxt = in_ch.displacement;
          ptr_nxt    = (ptr_r == PTR_LAST) ? '0 : ptr_r + 1'b1;
          fill_nxt   = (fill_r == SCAN_END) ? fill_r : fill_r + 1'b1;
          scan_idx_nxt = '0;
          ref_hit_nxt  = 1'b0;
          err_hit_nxt  = 1'b0;
          if (in_ch.restart_reference) begin
            refv_nxt  = 1'b0;
            taken_nxt = '0;
            sum_nxt   = '0;
          end
          if (in_ch.restart_reference || !refv_r) begin
            state_nxt = S_SQR;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SQR: begin
        state_nxt = S_ACC;
      end
      S_ACC: begin
        sum_nxt   = sum_add;
        taken_nxt = taken_inc;
        if (taken_inc >= target && taken_inc != '0) begin
          work_nxt  = {sum_add, MEAN_SHIFT'(0)};
          rem_nxt   = '0;
          iter_nxt  = DIV_LAST;
          state_nxt = S_DIV;
        end else begin
          res_cond_nxt = COND_NORMAL;
          res_rdy_nxt  = 1'b0;
          prev_nxt     = COND_NORMAL;
          state_nxt    = S_DONE;
        end
      end
      S_DIV: begin
        rem_nxt  = su_borrow ? div_trial[CNT_W-1:0] : su_diff[CNT_W-1:0];
        work_nxt = {work_r[DIV_W-2:0], !su_borrow};
        iter_nxt = iter_r - 1'b1;
        if (iter_r == '0) begin
          root_nxt  = '0;
          bit_nxt   = BIT_INIT;
          iter_nxt  = SQRT_LAST;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (!su_borrow) begin
          work_nxt = su_diff[DIV_W-1:0];
          root_nxt = (root_r >> 1) | bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt  = bit_r >> 2;
        iter_nxt = iter_r - 1'b1;
        if (iter_r == '0) begin
          ref_lvl_nxt = root_nxt[LEVEL_W-1:0];
          state_nxt   = S_ERRM;
        end
      end
      S_ERRM: begin
        state_nxt = S_ERRL;
      end
      S_ERRL: begin
        err_lvl_nxt  = prod_r[FRAC_SHIFT +: LEVEL_W];
        refv_nxt     = 1'b1;
        scan_idx_nxt = '0;
        ref_hit_nxt  = 1'b0;
        err_hit_nxt  = 1'b0;
        state_nxt    = S_SCAN;
      end
      S_SCAN: begin
        ref_hit_nxt = hit_ref_all;
        err_hit_nxt = hit_err_all;
        if (scan_idx_r != SCAN_END) begin
          scan_idx_nxt = scan_idx_r + 1'b1;
          pend_nxt     = 1'b1;
        end else if (!pend_r) begin
          res_cond_nxt = fin_cond;
          res_rdy_nxt  = 1'b1;
          prev_nxt     = fin_cond;
          state_nxt    = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_cond_nxt  = res_cond_r;
          out_rdy_nxt   = res_rdy_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      ref_samples_r <= REF_SAMPLES_RST;
      err_frac_r    <= ERR_FRAC_RST;
      ptr_r         <= '0;
      fill_r        <= '0;
      sum_r         <= '0;
      taken_r       <= '0;
      refv_r        <= 1'b0;
      ref_lvl_r     <= '0;
      err_lvl_r     <= '0;
      prev_r        <= COND_NORMAL;
      pend_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      taken_r     <= taken_nxt;
      refv_r      <= refv_nxt;
      ref_lvl_r   <= ref_lvl_nxt;
      err_lvl_r   <= err_lvl_nxt;
      prev_r      <= prev_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_paddr[2])
          REG_REF_SAMPLES: ref_samples_r <= cfg_pwdata[CNT_W-1:0];
          REG_ERR_FRAC:    err_frac_r    <= cfg_pwdata[FRAC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    sample_r   <= sample_nxt;
    prod_r     <= PROD_W'(mul_a * mul_b);
    rem_r      <= rem_nxt;
    work_r     <= work_nxt;
    root_r     <= root_nxt;
    bit_r      <= bit_nxt;
    iter_r     <= iter_nxt;
    scan_idx_r <= scan_idx_nxt;
    ref_hit_r  <= ref_hit_nxt;
    err_hit_r  <= err_hit_nxt;
    res_cond_r <= res_cond_nxt;
    res_rdy_r  <= res_rdy_nxt;
    out_cond_r <= out_cond_nxt;
    out_rdy_r  <= out_rdy_nxt;
  end

  // window memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept) begin
      win_mem[ptr_r] <= in_ch.displacement;
    end
    rdata_r <= win_mem[rd_addr];
    rd_ok_r <= (scan_idx_r < fill_r);
  end

endmodule

[hw/rtl/rard_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rard_checker: port-level checks of the apnea detector
// Watches the sample and result channels over time.
// ----------------------------------------------------------------------------
module rard_checker import rard_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input cond_t condition,
  input logic  reference_ready
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("sample accepted while previous sample still in work");

  a_cond_needs_ref: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (condition == COND_NORMAL) || reference_ready)
    else $error("non-normal condition without a reference");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(condition)
      && $stable(reference_ready))
    else $error("stalled result word changed");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result word present after reset");

endmodule

bind rms_reference_apnea_detector rard_checker u_rard_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .condition       (out_ch.condition),
  .reference_ready (out_ch.reference_ready)
);
